[src/cosh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosh_pkg
// Shared widths, register indexes, microcode format and the reciprocal table
// of the cosh series core.
// ----------------------------------------------------------------------------
package cosh_pkg;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned DATA_W    = 31;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned RECIP_W   = 30;
  localparam int unsigned PC_W      = 3;

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam logic [DATA_W-1:0] SUM_MAX  = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] SUM_INIT = DATA_W'(ONE);
  localparam logic [DATA_W-1:0] TERM_INIT = DATA_W'(ONE);

  // configuration register indexes
  localparam logic REG_ACCURACY_WINDOW = 1'b0;
  localparam logic REG_MAX_TERMS       = 1'b1;

  localparam logic [DATA_W-1:0] WINDOW_RESET    = 31'd1024;
  localparam logic [CNT_W-1:0]  MAX_TERMS_RESET = 6'd16;

  // rounded 1/((2k-1)*2k) in Q30, entry k-1
  localparam logic [RECIP_W-1:0] RECIP [MAX_TERMS] = '{
    30'((ONE + 1) / 2),       30'((ONE + 6) / 12),      30'((ONE + 15) / 30),
    30'((ONE + 28) / 56),     30'((ONE + 45) / 90),     30'((ONE + 66) / 132),
    30'((ONE + 91) / 182),    30'((ONE + 120) / 240),   30'((ONE + 153) / 306),
    30'((ONE + 190) / 380),   30'((ONE + 231) / 462),   30'((ONE + 276) / 552),
    30'((ONE + 325) / 650),   30'((ONE + 378) / 756),   30'((ONE + 435) / 870),
    30'((ONE + 496) / 992),   30'((ONE + 561) / 1122),  30'((ONE + 630) / 1260),
    30'((ONE + 703) / 1406),  30'((ONE + 780) / 1560),  30'((ONE + 861) / 1722),
    30'((ONE + 946) / 1892),  30'((ONE + 1035) / 2070), 30'((ONE + 1128) / 2256),
    30'((ONE + 1225) / 2450), 30'((ONE + 1326) / 2652), 30'((ONE + 1431) / 2862),
    30'((ONE + 1540) / 3080), 30'((ONE + 1653) / 3306), 30'((ONE + 1770) / 3540),
    30'((ONE + 1891) / 3782), 30'((ONE + 2016) / 4032)
  };

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQR,
    OP_MTX,
    OP_MTR,
    OP_ACC,
    OP_EMIT
  } op_t;

  // sequencing condition
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_ACCEPT,
    SEQ_BRANCH,
    SEQ_WAIT_OUT
  } seq_t;

  typedef struct packed {
    op_t             op;
    seq_t            seq;
    logic [PC_W-1:0] tgt;
    logic [PC_W-1:0] alt;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_SQR  = 3'd1;
  localparam logic [PC_W-1:0] PC_MTX  = 3'd2;
  localparam logic [PC_W-1:0] PC_MTR  = 3'd3;
  localparam logic [PC_W-1:0] PC_ACC  = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT = 3'd5;

  // control store: tgt is the taken path, alt the loop-back on branch steps
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE: w = '{op: OP_LOAD, seq: SEQ_ACCEPT,   tgt: PC_SQR,  alt: PC_IDLE};
      PC_SQR:  w = '{op: OP_SQR,  seq: SEQ_NEXT,     tgt: PC_MTX,  alt: PC_MTX};
      PC_MTX:  w = '{op: OP_MTX,  seq: SEQ_NEXT,     tgt: PC_MTR,  alt: PC_MTR};
      PC_MTR:  w = '{op: OP_MTR,  seq: SEQ_NEXT,     tgt: PC_ACC,  alt: PC_ACC};
      PC_ACC:  w = '{op: OP_ACC,  seq: SEQ_BRANCH,   tgt: PC_EMIT, alt: PC_MTX};
      PC_EMIT: w = '{op: OP_EMIT, seq: SEQ_WAIT_OUT, tgt: PC_IDLE, alt: PC_EMIT};
      default: w = '{op: OP_NOP,  seq: SEQ_NEXT,     tgt: PC_IDLE, alt: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/cosh_taylor_series_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosh_taylor_series_core
// Maclaurin series of cosh in Q1.30 with an accuracy-window stop test.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: in_arg_x (signed Q1.30) and
//   in_reference_value (unsigned Q1.30). out_valid/out_ready return one
//   result per request: out_series_sum, out_reached and out_terms_used.
//   cfg_we writes accuracy_window (index 0) or max_terms (index 1) from
//   cfg_wdata; write only while the core is idle.
// Timing:
//   a microcoded sequencer runs the shared 31x31 multiplier. From acceptance
//   to the result register a request runs one squaring step, then two
//   multiplies and one add/test step per term, for n terms added (1 to 32).
//   A new request is taken only once the previous result is in the output
//   register.
// Reset:
//   rst_n (synchronous, active low) returns the sequencer to idle, drops
//   out_valid and loads the register defaults (window 1024, 16 terms).
// Stall:
//   a finished result waits in the output register while out_ready is low;
//   the next request is then computed and held until that slot frees up.
// ----------------------------------------------------------------------------
module cosh_taylor_series_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [cosh_pkg::DATA_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [cosh_pkg::DATA_W-1:0] in_arg_x,
  input  logic [cosh_pkg::DATA_W-1:0]   in_reference_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cosh_pkg::DATA_W-1:0]   out_series_sum,
  output logic                          out_reached,
  output logic [cosh_pkg::CNT_W-1:0]    out_terms_used
);

  localparam int unsigned W = cosh_pkg::DATA_W;
  localparam int unsigned CW = cosh_pkg::CNT_W;

  // configuration
  logic [W-1:0]  window_r;
  logic [CW-1:0] max_terms_r;

  // sequencer
  logic [cosh_pkg::PC_W-1:0] pc_r, pc_nxt;
  cosh_pkg::uword_t          uw;

  // datapath
  logic [W-1:0]  mag_r, mag_nxt;
  logic [W-1:0]  x2_r, x2_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [W-1:0]  term_r, term_nxt;
  logic [W-1:0]  sum_r, sum_nxt;
  logic [W:0]    hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic          hit_r, hit_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_sum_r, out_sum_nxt;
  logic          out_reached_r, out_reached_nxt;
  logic [CW-1:0] out_terms_r, out_terms_nxt;

  // shared multiplier
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;
  logic [W-1:0]   prod_q;

  logic [W:0]    acc_sum;
  logic [W-1:0]  acc_sat;
  logic [CW-1:0] cnt_inc;
  logic          acc_hit;
  logic          out_free;
  logic          in_fire;

  assign uw       = cosh_pkg::ucode(pc_r);
  assign in_ready = (uw.seq == cosh_pkg::SEQ_ACCEPT);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    mul_a = mag_r;
    mul_b = mag_r;
    case (uw.op)
      cosh_pkg::OP_MTX: begin
        mul_a = term_r;
        mul_b = x2_r;
      end
      cosh_pkg::OP_MTR: begin
        mul_a = p_r;
        mul_b = W'(cosh_pkg::RECIP[cnt_r[cosh_pkg::IDX_W-1:0]]);
      end
      default: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
    endcase
  end

  // operands never exceed 1.0, so the shifted product fits in 31 bits
  assign prod   = mul_a * mul_b;
  assign prod_q = prod[cosh_pkg::FRAC_BITS +: W];

  assign acc_sum = {1'b0, sum_r} + {1'b0, term_r};
  assign acc_sat = acc_sum[W] ? cosh_pkg::SUM_MAX : acc_sum[W-1:0];
  assign cnt_inc = cnt_r + CW'(1);
  assign acc_hit = ({1'b0, acc_sat} <= hi_r) && (acc_sat >= lo_r);

  always_comb begin
    pc_nxt          = pc_r;
    mag_nxt         = mag_r;
    x2_nxt          = x2_r;
    p_nxt           = p_r;
    term_nxt        = term_r;
    sum_nxt         = sum_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    cnt_nxt         = cnt_r;
    limit_nxt       = limit_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_sum_nxt     = out_sum_r;
    out_reached_nxt = out_reached_r;
    out_terms_nxt   = out_terms_r;

    case (uw.op)
      cosh_pkg::OP_LOAD: begin
        if (in_fire) begin
          // |x|; the most negative code maps to 1.0
          mag_nxt  = in_arg_x[W-1] ? W'(~in_arg_x + 1'b1) : W'(in_arg_x);
          hi_nxt   = {1'b0, in_reference_value} + {1'b0, window_r};
          lo_nxt   = (in_reference_value >= window_r) ?
                     (in_reference_value - window_r) : '0;
          term_nxt = cosh_pkg::TERM_INIT;
          sum_nxt  = cosh_pkg::SUM_INIT;
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          if (max_terms_r == '0) begin
            limit_nxt = CW'(1);
          end else if (max_terms_r > CW'(cosh_pkg::MAX_TERMS)) begin
            limit_nxt = CW'(cosh_pkg::MAX_TERMS);
          end else begin
            limit_nxt = max_terms_r;
          end
        end
      end
      cosh_pkg::OP_SQR: x2_nxt = prod_q;
      cosh_pkg::OP_MTX: p_nxt = prod_q;
      cosh_pkg::OP_MTR: term_nxt = prod_q;
      cosh_pkg::OP_ACC: begin
        sum_nxt = acc_sat;
        cnt_nxt = cnt_inc;
        hit_nxt = acc_hit;
      end
      cosh_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_sum_nxt     = sum_r;
          out_reached_nxt = hit_r;
          out_terms_nxt   = cnt_r;
        end
      end
      default: ;
    endcase

    case (uw.seq)
      cosh_pkg::SEQ_NEXT:     pc_nxt = uw.tgt;
      cosh_pkg::SEQ_ACCEPT:   pc_nxt = in_fire ? uw.tgt : pc_r;
      cosh_pkg::SEQ_BRANCH:   pc_nxt = (acc_hit || cnt_inc == limit_r) ? uw.tgt : uw.alt;
      cosh_pkg::SEQ_WAIT_OUT: pc_nxt = out_free ? uw.tgt : uw.alt;
      default:                pc_nxt = cosh_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= cosh_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
      window_r    <= cosh_pkg::WINDOW_RESET;
      max_terms_r <= cosh_pkg::MAX_TERMS_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          cosh_pkg::REG_ACCURACY_WINDOW: window_r <= cfg_wdata;
          cosh_pkg::REG_MAX_TERMS:       max_terms_r <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
    end
    mag_r         <= mag_nxt;
    x2_r          <= x2_nxt;
    p_r           <= p_nxt;
    term_r        <= term_nxt;
    sum_r         <= sum_nxt;
    hi_r          <= hi_nxt;
    lo_r          <= lo_nxt;
    cnt_r         <= cnt_nxt;
    limit_r       <= limit_nxt;
    hit_r         <= hit_nxt;
    out_sum_r     <= out_sum_nxt;
    out_reached_r <= out_reached_nxt;
    out_terms_r   <= out_terms_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_series_sum = out_sum_r;
  assign out_reached    = out_reached_r;
  assign out_terms_used = out_terms_r;

endmodule
